[rtl/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, constants and helpers for the keypad scanner with its
// four-digit nibble display.
// ----------------------------------------------------------------------------
package kpd_pkg;

    // Debounce counter width (4 to 32)
    localparam int WAIT_WIDTH  = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_WIDTH  = 3;

    // Register map
    localparam logic [ADDR_WIDTH-1:0] ADDR_DEBOUNCE = 3'd0;
    localparam logic [CFG_WIDTH-1:0]  DEBOUNCE_RESET = 16'd50;

    // Key that clears the display
    localparam logic [3:0] KEY_CLEAR = 4'd15;

    typedef enum logic [1:0] {
        PH_SCAN         = 2'd0,
        PH_PRESS_WAIT   = 2'd1,
        PH_RELEASE      = 2'd2,
        PH_RELEASE_WAIT = 2'd3
    } t_phase;

    // One result beat
    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        logic [3:0] key_code;
        logic [7:0] display_low;
        logic [7:0] display_high;
    } t_result;

    // Key map, column then row
    function automatic logic [3:0] key_map(input logic [1:0] col, input logic [1:0] row);
        logic [3:0] code;
        case ({col, row})
            4'h0: code = 4'd13;
            4'h1: code = 4'd12;
            4'h2: code = 4'd11;
            4'h3: code = 4'd10;
            4'h4: code = 4'd15;
            4'h5: code = 4'd9;
            4'h6: code = 4'd6;
            4'h7: code = 4'd3;
            4'h8: code = 4'd0;
            4'h9: code = 4'd8;
            4'hA: code = 4'd5;
            4'hB: code = 4'd2;
            4'hC: code = 4'd14;
            4'hD: code = 4'd7;
            4'hE: code = 4'd4;
            default: code = 4'd1;
        endcase
        return code;
    endfunction

    // Wait length loaded into the counter, saturated to the counter width
    function automatic logic [WAIT_WIDTH-1:0] wait_load(input logic [CFG_WIDTH-1:0] d);
        logic [32:0] dx;
        logic [32:0] lim;
        dx  = 33'(d);
        lim = (33'(1) << WAIT_WIDTH) - 33'(1);
        return WAIT_WIDTH'((dx > lim) ? lim : dx);
    endfunction

endpackage

[rtl/kpd_cfg.sv]
// ----------------------------------------------------------------------------
// kpd_cfg
// APB register file holding the debounce length.
// ----------------------------------------------------------------------------
module kpd_cfg
    import kpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output logic [CFG_WIDTH-1:0]  o_debounce
);

    logic [CFG_WIDTH-1:0] r_debounce;
    logic                 sel_debounce;
    logic                 wr_en;

    // Word decode: low two bits are byte offset
    assign sel_debounce = (paddr[ADDR_WIDTH-1:2] == ADDR_DEBOUNCE[ADDR_WIDTH-1:2]);
    assign pready       = 1'b1;
    assign wr_en        = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (wr_en && sel_debounce) begin
            r_debounce <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // Read back
    assign prdata     = sel_debounce ? DATA_WIDTH'(r_debounce) : '0;
    assign o_debounce = r_debounce;

endmodule

[rtl/kpd_core.sv]
// ----------------------------------------------------------------------------
// kpd_core
// Scan state machine: column walk, press/release debounce and the digit
// shift register. State moves one tick per accepted beat.
// ----------------------------------------------------------------------------
module kpd_core
    import kpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [3:0]           i_row_lines,
    input  logic [CFG_WIDTH-1:0] i_debounce,
    output t_result              o_result
);

    t_phase                r_phase, n_phase;
    logic [1:0]            r_scan_column, n_scan_column;
    logic [WAIT_WIDTH-1:0] r_wait_count, n_wait_count;
    logic [1:0]            r_held_row, n_held_row;
    logic [3:0]            r_held_code, n_held_code;
    logic [15:0]           r_digit_store, n_digit_store;

    logic [1:0]            first_row;
    logic                  found;
    logic                  wait_done;
    logic                  released;
    logic                  report;

    // First pressed row, lowest index wins
    always_comb begin
        first_row = 2'd0;
        for (int r = 3; r >= 0; r--) begin
            if (!i_row_lines[r]) begin
                first_row = 2'(r);
            end
        end
    end

    assign found     = ~&i_row_lines;
    assign wait_done = (r_wait_count <= WAIT_WIDTH'(1));
    assign released  = i_row_lines[r_held_row];

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_SCAN:         if (found)     n_phase = PH_PRESS_WAIT;
            PH_PRESS_WAIT:   if (wait_done) n_phase = PH_RELEASE;
            PH_RELEASE:      if (released)  n_phase = PH_RELEASE_WAIT;
            PH_RELEASE_WAIT: if (wait_done) n_phase = PH_SCAN;
            default:         n_phase = PH_SCAN;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_scan_column = r_scan_column;
        n_wait_count  = r_wait_count;
        n_held_row    = r_held_row;
        n_held_code   = r_held_code;
        n_digit_store = r_digit_store;
        report        = 1'b0;
        case (r_phase)
            PH_SCAN: begin
                if (found) begin
                    n_held_row   = first_row;
                    n_held_code  = key_map(r_scan_column, first_row);
                    n_wait_count = wait_load(i_debounce);
                end else begin
                    n_scan_column = r_scan_column + 2'd1;
                end
            end
            PH_PRESS_WAIT: begin
                n_wait_count = wait_done ? '0 : r_wait_count - WAIT_WIDTH'(1);
            end
            PH_RELEASE: begin
                if (released) begin
                    n_wait_count = wait_load(i_debounce);
                end
            end
            PH_RELEASE_WAIT: begin
                n_wait_count = wait_done ? '0 : r_wait_count - WAIT_WIDTH'(1);
                if (wait_done) begin
                    report        = 1'b1;
                    n_scan_column = 2'd0;
                    n_digit_store = (r_held_code == KEY_CLEAR) ? 16'd0
                                  : {r_digit_store[11:0], r_held_code};
                end
            end
            default: ;
        endcase

        o_result.column_drive = ~(4'd1 << r_scan_column);
        o_result.key_valid    = report;
        o_result.key_code     = report ? r_held_code : 4'd0;
        o_result.display_low  = n_digit_store[7:0];
        o_result.display_high = n_digit_store[15:8];
    end

    // State registers, stepped once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SCAN;
            r_scan_column <= 2'd0;
            r_wait_count  <= '0;
            r_held_row    <= 2'd0;
            r_held_code   <= 4'd0;
            r_digit_store <= 16'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_scan_column <= n_scan_column;
            r_wait_count  <= n_wait_count;
            r_held_row    <= n_held_row;
            r_held_code   <= n_held_code;
            r_digit_store <= n_digit_store;
        end
    end

`ifndef SYNTHESIS
    // A report returns the scanner to column 0
    a_report_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.key_valid) |=> (r_phase == PH_SCAN && r_scan_column == 2'd0))
        else $error("scan did not restart after report");

    // Idle scan tick walks to the next column
    a_column_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_SCAN && (&i_row_lines))
        |=> (r_scan_column == $past(r_scan_column) + 2'd1))
        else $error("column did not advance");

    // Exactly one column driven low
    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(~o_result.column_drive))
        else $error("column drive not one-cold");

    // Press wait never lasts past the loaded length without leaving
    a_wait_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_PRESS_WAIT && wait_done) |=> (r_phase == PH_RELEASE))
        else $error("press wait did not end");
`endif

endmodule

[rtl/kpd_out.sv]
// ----------------------------------------------------------------------------
// kpd_out
// Result register between the scan logic and the output channel.
// ----------------------------------------------------------------------------
module kpd_out
    import kpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_space
);

    logic    r_valid;
    t_result r_result;

    // Space when empty or the held beat leaves this cycle
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/keypad_scan_digit_display.sv]
// ----------------------------------------------------------------------------
// keypad_scan_digit_display
// 4x4 keypad scanner with press/release debounce and a four-digit display.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_row_lines
//   output    out        o_valid / i_ready    o_column_drive, o_key_valid,
//                                             o_key_code, o_display_low/high
//   config    in         APB psel/penable     debounce_ticks at 0x0
//
// One tick per cycle: a row sample is taken every cycle that the result
// register is empty or being drained, and its result appears the next cycle.
// The result is held in the single result register.
// Synchronous active-low reset clears the scan state and display; debounce
// returns to 50 ticks. A stalled output holds its beat and stops input.
// ----------------------------------------------------------------------------
module keypad_scan_digit_display
    import kpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_row_lines,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [3:0]            o_column_drive,
    output logic                  o_key_valid,
    output logic [3:0]            o_key_code,
    output logic [7:0]            o_display_low,
    output logic [7:0]            o_display_high,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    logic [CFG_WIDTH-1:0] debounce;
    logic                 fire;
    logic                 space;
    t_result              core_result;
    t_result              out_result;

    assign o_ready = space;
    assign fire    = i_valid && space;

    // Configuration registers
    kpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_debounce (debounce)
    );

    // Scan state machine
    kpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_row_lines (i_row_lines),
        .i_debounce  (debounce),
        .o_result    (core_result)
    );

    // Result register
    kpd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (out_result),
        .o_space  (space)
    );

    assign o_column_drive = out_result.column_drive;
    assign o_key_valid    = out_result.key_valid;
    assign o_key_code     = out_result.key_code;
    assign o_display_low  = out_result.display_low;
    assign o_display_high = out_result.display_high;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 keypad scanner with its nibble display.
// A directed table walks one press of each kind, then row samples are shaped
// from a running model of the scanner, like fingers on the keys. Every
// result beat is compared field by field against the table or the model's output.
// Debounce is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module testbench;
    import kpd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DIR_LEN      = 22;
    localparam int PHASE_ITEMS  = 100;
    // Key codes by {column, row}, one nibble each, index 0 at the bottom
    localparam logic [63:0] KEY_CODES = 64'h147E_2580_369F_ABCD;

    typedef struct packed {
        logic [3:0] rows;
        logic       typed;
        t_result    want;
    } t_vec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [3:0]            i_row_lines;
    logic                  o_valid;
    logic                  i_ready;
    logic [3:0]            o_column_drive;
    logic                  o_key_valid;
    logic [3:0]            o_key_code;
    logic [7:0]            o_display_low;
    logic [7:0]            o_display_high;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    keypad_scan_digit_display dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_row_lines    (i_row_lines),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_column_drive (o_column_drive),
        .o_key_valid    (o_key_valid),
        .o_key_code     (o_key_code),
        .o_display_low  (o_display_low),
        .o_display_high (o_display_high),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Scanner model state
    logic [1:0]            m_col;
    t_phase                m_phase;
    logic [WAIT_WIDTH-1:0] m_wait;
    logic [1:0]            m_row;
    logic [3:0]            m_code;
    logic [15:0]           m_digits;
    logic [15:0]           m_debounce;

    t_result tick_results [$];
    t_vec    dir_tbl [DIR_LEN];
    int      err_count;
    int      cycles;
    int      key_reports;
    int      stall_left;
    bit      idle_on;
    logic [1:0] tgt_col;
    logic [1:0] tgt_row;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results still pending", $time, tick_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Wait length loaded into the debounce counter, saturated to its width
    function automatic logic [WAIT_WIDTH-1:0] debounce_len();
        logic [32:0] cap;
        cap = (33'd1 << WAIT_WIDTH) - 33'd1;
        return WAIT_WIDTH'((33'(m_debounce) > cap) ? cap : 33'(m_debounce));
    endfunction

    // One scan tick of the model: advances state, returns the result beat
    function automatic t_result scan_tick(input logic [3:0] rows);
        t_result    res;
        logic       found;
        logic [1:0] hit;
        int         k;
        res.column_drive = ~(4'b0001 << m_col);
        res.key_valid    = 1'b0;
        res.key_code     = 4'd0;
        case (m_phase)
            PH_SCAN: begin
                found = 1'b0;
                hit   = 2'd0;
                // walk down so the lowest low row is the one kept
                for (k = 3; k >= 0; k--) begin
                    if (!rows[k]) begin
                        found = 1'b1;
                        hit   = 2'(k);
                    end
                end
                if (found) begin
                    m_row   = hit;
                    m_code  = KEY_CODES[{m_col, hit}*4 +: 4];
                    m_wait  = debounce_len();
                    m_phase = PH_PRESS_WAIT;
                end else begin
                    m_col = m_col + 2'd1;
                end
            end
            PH_PRESS_WAIT: begin
                if (m_wait <= 1) begin
                    m_wait  = '0;
                    m_phase = PH_RELEASE;
                end else begin
                    m_wait = m_wait - 1'b1;
                end
            end
            PH_RELEASE: begin
                if (rows[m_row]) begin
                    m_wait  = debounce_len();
                    m_phase = PH_RELEASE_WAIT;
                end
            end
            default: begin
                if (m_wait <= 1) begin
                    m_wait        = '0;
                    res.key_valid = 1'b1;
                    res.key_code  = m_code;
                    m_digits      = (m_code == KEY_CLEAR) ? 16'h0000 : {m_digits[11:0], m_code};
                    m_phase       = PH_SCAN;
                    m_col         = 2'd0;
                end else begin
                    m_wait = m_wait - 1'b1;
                end
            end
        endcase
        res.display_low  = m_digits[7:0];
        res.display_high = m_digits[15:8];
        return res;
    endfunction

    // Row sample shaped by the model: press the target key when its column
    // is driven, hold or let go of the held row, random lines during waits
    function automatic logic [3:0] pick_rows();
        logic [3:0] r;
        r = 4'($urandom);
        case (m_phase)
            PH_SCAN: begin
                if (m_col == tgt_col)
                    r = (r | ((4'b0001 << tgt_row) - 4'd1)) & ~(4'b0001 << tgt_row);
                else if ($urandom_range(0, 9) != 0)
                    r = 4'hF;
            end
            PH_RELEASE: begin
                if ($urandom_range(0, 2) != 0)
                    r = r & ~(4'b0001 << m_row);
                else
                    r = r | (4'b0001 << m_row);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tick_results.size() == 0) begin
                $display("%0t unexpected result beat: drive %0h valid %0b code %0h", $time,
                         o_column_drive, o_key_valid, o_key_code);
                err_count++;
            end else begin
                want = tick_results.pop_front();
                cmp_field("column_drive", 8'(want.column_drive), 8'(o_column_drive));
                cmp_field("key_valid", 8'(want.key_valid), 8'(o_key_valid));
                cmp_field("key_code", 8'(want.key_code), 8'(o_key_code));
                cmp_field("display_low", want.display_low, o_display_low);
                cmp_field("display_high", want.display_high, o_display_high);
            end
        end
    end

    // Receiver stalls in bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Drive one row beat, wait for it to be taken, queue its expected result
    task automatic send_rows(input logic [3:0] rows, input logic typed, input t_result want);
        t_result got;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_row_lines <= rows;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        got = scan_tick(rows);
        tick_results.push_back(typed ? want : got);
        if (got.key_valid) begin
            key_reports++;
            {tgt_col, tgt_row} = 4'($urandom);
        end
    endtask

    // Stop sending and let every pending result drain
    task automatic drain();
        i_valid <= 1'b0;
        while (tick_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write: setup, then access until pready
    task automatic write_reg(input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DEBOUNCE)
            m_debounce = data[15:0];
    endtask

    // Main sequence
    initial begin
        int          ph;
        int          cnt;
        int          min_keys;
        logic [15:0] dbv;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_row_lines <= 4'hF;
        i_ready     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        err_count   = 0;
        cycles      = 0;
        key_reports = 0;
        stall_left  = 0;
        idle_on     = 1'b1;
        tgt_col     = 2'd0;
        tgt_row     = 2'd0;
        m_col       = 2'd0;
        m_phase     = PH_SCAN;
        m_wait      = '0;
        m_row       = 2'd0;
        m_code      = 4'd0;
        m_digits    = 16'h0000;
        m_debounce  = DEBOUNCE_RESET;

        // Directed table, run with debounce 0 (each wait one tick)
        //              rows   typed  drive valid code low    high
        dir_tbl[0]  = {4'hF, 1'b1, 4'hE, 1'b0, 4'h0, 8'h00, 8'h00}; // after reset
        dir_tbl[1]  = {4'hD, 1'b0, 25'd0};                          // col 1 row 1: key 9
        dir_tbl[2]  = {4'h0, 1'b0, 25'd0};                          // ignored in wait
        dir_tbl[3]  = {4'h0, 1'b0, 25'd0};                          // still held
        dir_tbl[4]  = {4'h2, 1'b0, 25'd0};                          // held row released
        dir_tbl[5]  = {4'hF, 1'b1, 4'hD, 1'b1, 4'h9, 8'h09, 8'h00};
        dir_tbl[6]  = {4'h0, 1'b0, 25'd0};                          // all rows: row 0 wins
        dir_tbl[7]  = {4'hF, 1'b0, 25'd0};
        dir_tbl[8]  = {4'hF, 1'b0, 25'd0};
        dir_tbl[9]  = {4'hF, 1'b1, 4'hE, 1'b1, 4'hD, 8'h9D, 8'h00};
        dir_tbl[10] = {4'hF, 1'b0, 25'd0};
        dir_tbl[11] = {4'hE, 1'b0, 25'd0};                          // clear key
        dir_tbl[12] = {4'hF, 1'b0, 25'd0};
        dir_tbl[13] = {4'hF, 1'b0, 25'd0};
        dir_tbl[14] = {4'hF, 1'b1, 4'hD, 1'b1, 4'hF, 8'h00, 8'h00};
        dir_tbl[15] = {4'hF, 1'b0, 25'd0};
        dir_tbl[16] = {4'hF, 1'b0, 25'd0};
        dir_tbl[17] = {4'hF, 1'b0, 25'd0};
        dir_tbl[18] = {4'h7, 1'b0, 25'd0};                          // col 3 row 3: key 1
        dir_tbl[19] = {4'hF, 1'b0, 25'd0};
        dir_tbl[20] = {4'hF, 1'b0, 25'd0};
        dir_tbl[21] = {4'hF, 1'b1, 4'h7, 1'b1, 4'h1, 8'h01, 8'h00};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(ADDR_DEBOUNCE, 32'd0);

        for (int n = 0; n < DIR_LEN; n++)
            send_rows(dir_tbl[n].rows, dir_tbl[n].typed, dir_tbl[n].want);

        // Random phases; the last one runs without idling until a key is reported
        for (ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                0: dbv = 16'd1;
                1: dbv = 16'd0;
                2: dbv = 16'd3;
                3: dbv = 16'd2;
                4: dbv = 16'($urandom_range(0, 6));
                5: dbv = DEBOUNCE_RESET;
                default: dbv = 16'd9;
            endcase
            write_reg(ADDR_DEBOUNCE, 32'(dbv));
            idle_on  = (ph != 2) && (ph != 6);
            min_keys = key_reports + ((ph == 6) ? 1 : 0);
            cnt      = 0;
            while (cnt < ((ph == 6) ? 0 : PHASE_ITEMS) || key_reports < min_keys) begin
                send_rows(pick_rows(), 1'b0, '0);
                cnt++;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
